>>> src/fls_pkg.sv
// shared types and constants of the free-list slot tracker
`default_nettype none

package fls_pkg;

    // default table depth
    localparam int SLOTS_DEF = 1024;

    // request and result field widths
    localparam int IDX_W    = 10;
    localparam int TAG_W    = 32;
    localparam int SIZE_W   = 31;
    localparam int STATUS_W = 3;

    // request modes
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // configuration port: one byte address bit above the word offset
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_TRACK_EN = 1'b0;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DISABLED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_HEAD_BUSY = 3'd3,
        ST_RANGE     = 3'd4,
        ST_MISMATCH  = 3'd5,
        ST_ZERO_TAG  = 3'd6
    } t_status;

    // request transfer
    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  slot_index;
        logic [TAG_W-1:0]  record_tag;
        logic [SIZE_W-1:0] record_size;
    } t_req;

    // result transfer
    typedef struct packed {
        logic [IDX_W-1:0] granted_slot;
        t_status          status;
    } t_rsp;

endpackage

`default_nettype wire

>>> src/fls_ram.sv
// single-port-write, registered-read memory for the slot table
`default_nettype none

module fls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fls_pkg::SLOTS_DEF,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/fls_core.sv
// request sequencer: reads a slot, checks it and writes back the table and free list
`default_nettype none

module fls_core #(
    parameter int SLOTS = fls_pkg::SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_enable,
    input  wire logic          i_start,
    input  wire fls_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_valid,
    output fls_pkg::t_rsp      o_rsp
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW   = $clog2(SLOTS + 1);
    localparam int CMPW = (HW > fls_pkg::IDX_W) ? HW : fls_pkg::IDX_W;
    localparam int RW   = fls_pkg::TAG_W + fls_pkg::SIZE_W;
    localparam logic [HW-1:0] END_MARK = HW'(SLOTS);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state        r_state,  n_state;
    logic [HW-1:0] r_head,   n_head;
    logic [HW-1:0] r_fill,   n_fill;
    logic          r_valid,  n_valid;
    fls_pkg::t_rsp r_rsp,    n_rsp;
    fls_pkg::t_req r_req;
    logic [IW-1:0] r_slot;

    logic [IW-1:0]                 rd_addr;
    logic [HW-1:0]                 link_rdata;
    logic [RW-1:0]                 rec_rdata;
    logic                          link_we;
    logic [HW-1:0]                 link_wdata;
    logic                          rec_we;
    logic [RW-1:0]                 rec_wdata;
    logic                          accept;
    logic                          fresh;
    logic                          empty;
    logic [fls_pkg::TAG_W-1:0]     cur_tag;
    logic [fls_pkg::SIZE_W-1:0]    cur_size;
    logic [HW-1:0]                 cur_link;
    logic                          idx_range;

    assign accept = i_start && (r_state == S_IDLE);

    // read address: head slot for add, named slot for remove
    assign rd_addr = (i_req.mode == fls_pkg::MODE_ADD) ? IW'(r_head)
                                                        : IW'(i_req.slot_index);

    // capture the request and its slot at the transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_slot <= rd_addr;
        end
    end

    fls_ram #(.WIDTH(HW), .DEPTH(SLOTS), .AW(IW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_slot),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    fls_ram #(.WIDTH(RW), .DEPTH(SLOTS), .AW(IW)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_slot),
        .i_wdata (rec_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rec_rdata)
    );

    // slots at or above the fill mark were never written: empty record, link to next
    assign fresh    = HW'(r_slot) >= r_fill;
    assign cur_tag  = fresh ? '0 : rec_rdata[RW-1 -: fls_pkg::TAG_W];
    assign cur_size = fresh ? '0 : rec_rdata[fls_pkg::SIZE_W-1:0];
    assign cur_link = fresh ? HW'(r_slot) + HW'(1) : link_rdata;
    assign empty    = r_head >= END_MARK;
    assign idx_range = CMPW'(r_req.slot_index) < CMPW'(SLOTS);

    // decide the request and the write-back
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        link_we    = 1'b0;
        link_wdata = empty ? END_MARK : r_head;
        rec_we     = 1'b0;
        rec_wdata  = {r_req.record_tag, r_req.record_size};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state            = S_IDLE;
                n_valid            = 1'b1;
                n_rsp.granted_slot = '0;
                n_rsp.status       = fls_pkg::ST_OK;
                if (!i_enable) begin
                    n_rsp.status = fls_pkg::ST_DISABLED;
                end else if (r_req.record_tag == '0) begin
                    n_rsp.status = fls_pkg::ST_ZERO_TAG;
                end else if (r_req.mode == fls_pkg::MODE_ADD) begin
                    if (empty) begin
                        n_rsp.status = fls_pkg::ST_FULL;
                    end else if (cur_tag != '0) begin
                        n_rsp.status = fls_pkg::ST_HEAD_BUSY;
                    end else begin
                        // pop the head and store the record
                        rec_we             = 1'b1;
                        n_head             = cur_link;
                        n_rsp.granted_slot = fls_pkg::IDX_W'(r_slot);
                        if (fresh) begin
                            n_fill = r_fill + HW'(1);
                        end
                    end
                end else begin
                    if (!idx_range) begin
                        n_rsp.status = fls_pkg::ST_RANGE;
                    end else if (cur_tag != r_req.record_tag ||
                                 cur_size != r_req.record_size) begin
                        n_rsp.status = fls_pkg::ST_MISMATCH;
                    end else begin
                        // clear the record and push the slot
                        rec_we    = 1'b1;
                        rec_wdata = '0;
                        link_we   = 1'b1;
                        n_head    = HW'(r_slot);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, free-list head, fill mark and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_busy  = (r_state == S_EXEC);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

>>> src/free_list_slot_tracker.sv
// top level of the free-list slot tracker: configuration port and request sequencer
//
// Keeps a table of SLOTS records (tag, size) with a linked free list.
// Request channel: drive i_req and raise start; the transfer happens at a
// rising edge with start high and busy low. mode add pops the free-list head
// and stores the record there; mode remove checks the named slot against the
// given tag and size and, on a match, clears it and pushes it on the list.
// Result channel: o_valid is high for one cycle with o_rsp (granted slot and
// status); the receiver cannot stall it, it is taken in that cycle.
// Timing: the transfer edge registers the read of the link and record
// memories, and the next cycle, with busy high, checks and writes back.
// o_valid is registered from that check and rises at the edge at which busy
// falls; a new request can be taken at the same edge at which the result is
// taken, so a request is never taken while another is in flight.
// Reset: tracking is off, the head is slot 0 and the table reads empty at
// once; a fill mark stands in for the initial contents, so there is no
// clearing pass. tracking_enable lies at byte address 0 of the APB port; the
// user must write it only while no request is in flight; the block does not check.
`default_nettype none

module free_list_slot_tracker #(
    parameter int SLOTS = fls_pkg::SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire fls_pkg::t_req                i_req,
    // result channel
    output logic                              o_valid,
    output fls_pkg::t_rsp                     o_rsp,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fls_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fls_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fls_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    logic r_track_en;
    logic cfg_wr;
    logic [fls_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fls_pkg::PADDR_W-1 -: fls_pkg::REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_en <= 1'b0;
        end else if (cfg_wr && reg_idx == fls_pkg::REG_TRACK_EN) begin
            r_track_en <= pwdata[0];
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        if (reg_idx == fls_pkg::REG_TRACK_EN) begin
            prdata[0] = r_track_en;
        end
    end

    fls_core #(.SLOTS(SLOTS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (r_track_en),
        .i_start  (start),
        .i_req    (i_req),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp)
    );

    // every accepted request is followed by its result
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after request transfer");

    // a result never coincides with a request in flight
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // no two results back to back
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a granted slot only with success
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.granted_slot != '0) |-> (o_rsp.status == fls_pkg::ST_OK))
        else $error("nonzero granted slot on a failed request");

endmodule

`default_nettype wire
